// ===== hw/rtl/psrl_pkg.sv =====
`timescale 1ns / 1ps
package psrl_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int USED_W      = $clog2(TABLE_DEPTH + 1);
    localparam int KEY_W       = 52;
    localparam int TIME_W      = 32;
    localparam int CTR_W       = 16;
    localparam int CMD_W       = 3;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int S_DATA_W    = 88;
    localparam int M_DATA_W    = 16;

    localparam logic [CTR_W-1:0] CTR_MAX = '1;

    // operation codes
    localparam logic [CMD_W-1:0] CMD_CHECK_CMD   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_CHECK_REPLY = 3'd1;
    localparam logic [CMD_W-1:0] CMD_ACCEPTED    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_REJECTED    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_REPLY_SENT  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_QUERY       = 3'd5;
    // spare codes, no effect
    localparam logic [CMD_W-1:0] CMD_RSVD_A      = 3'd6;
    localparam logic [CMD_W-1:0] CMD_RSVD_B      = 3'd7;

    // result status codes
    localparam logic [1:0] ST_OK            = 2'd0;
    localparam logic [1:0] ST_IGNORED       = 2'd1;
    localparam logic [1:0] ST_RATE_LIMITED  = 2'd2;
    localparam logic [1:0] ST_REPLY_LIMITED = 2'd3;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_RATE_EN    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_CMD_WIN    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_CMD_LIMIT  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_REPLY_WIN  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_REPLY_LIM  = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_AUTO_EN    = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] CFG_REJ_THR    = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] CFG_IGN_DUR    = 3'd7;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_RD,
        S_CMP,
        S_ALLOC,
        S_EXPIRE,
        S_UPDATE,
        S_WRITE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic              rate_en;
        logic [TIME_W-1:0] cmd_win;
        logic [CTR_W-1:0]  cmd_limit;
        logic [TIME_W-1:0] reply_win;
        logic [CTR_W-1:0]  reply_limit;
        logic              auto_en;
        logic [CTR_W-1:0]  rej_thr;
        logic [TIME_W-1:0] ign_dur;
    } t_cfg;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [TIME_W-1:0] touch_time;
        logic [TIME_W-1:0] cmd_ws;
        logic [CTR_W-1:0]  cmd_cnt;
        logic [TIME_W-1:0] reply_ws;
        logic [CTR_W-1:0]  reply_cnt;
        logic [TIME_W-1:0] rej_ws;
        logic [CTR_W-1:0]  rej_cnt;
        logic              ign_flag;
        logic [TIME_W-1:0] ign_until;
    } t_rec;

    typedef struct packed {
        logic start;
        logic rd;
        logic cmp;
        logic alloc;
        logic expire;
        logic update;
        logic write;
    } t_dp_cmd;

    typedef struct packed {
        logic no_op;
        logic query;
        logic used_zero;
        logic hit;
        logic last;
    } t_dp_sts;

    function automatic logic window_over(input logic [TIME_W-1:0] start,
                                         input logic [TIME_W-1:0] now,
                                         input logic [TIME_W-1:0] len);
        return (start == '0) || (now < start) || ((now - start) >= len);
    endfunction

    function automatic logic [CTR_W-1:0] sat_inc(input logic [CTR_W-1:0] c);
        return (c == CTR_MAX) ? CTR_MAX : c + 1'b1;
    endfunction

endpackage

// ===== hw/rtl/psrl_ctrl.sv =====
`timescale 1ns / 1ps
module psrl_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_fire,
    input  logic              i_out_free,
    input  psrl_pkg::t_dp_sts i_sts,
    output psrl_pkg::t_dp_cmd o_cmd,
    output logic              o_in_ready,
    output logic              o_out_load
);
    import psrl_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_fire) n_state = S_DISPATCH;
            end
            S_DISPATCH: begin
                if (i_sts.no_op) n_state = S_DONE;
                else if (i_sts.used_zero) n_state = i_sts.query ? S_DONE : S_ALLOC;
                else n_state = S_RD;
            end
            S_RD: n_state = S_CMP;
            S_CMP: begin
                if (i_sts.hit) n_state = S_EXPIRE;
                else if (i_sts.last) n_state = i_sts.query ? S_DONE : S_ALLOC;
                else n_state = S_RD;
            end
            S_ALLOC:  n_state = S_EXPIRE;
            S_EXPIRE: n_state = S_UPDATE;
            S_UPDATE: n_state = S_WRITE;
            S_WRITE:  n_state = S_DONE;
            S_DONE: begin
                if (i_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        o_out_load = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.start = i_in_fire;
            end
            S_RD:     o_cmd.rd     = 1'b1;
            S_CMP:    o_cmd.cmp    = 1'b1;
            S_ALLOC:  o_cmd.alloc  = 1'b1;
            S_EXPIRE: o_cmd.expire = 1'b1;
            S_UPDATE: o_cmd.update = 1'b1;
            S_WRITE:  o_cmd.write  = 1'b1;
            S_DONE:   o_out_load   = i_out_free;
            default: ;
        endcase
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRITE) |-> ($past(r_state) == S_UPDATE))
        else $error("write without update");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> ($past(r_state) == S_RD))
        else $error("compare without read");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !o_out_load)
        else $error("accept and deliver overlap");

endmodule

// ===== hw/rtl/psrl_dp.sv =====
`timescale 1ns / 1ps
module psrl_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  psrl_pkg::t_cfg                  i_cfg,
    input  psrl_pkg::t_dp_cmd               i_cmd,
    input  logic [psrl_pkg::CMD_W-1:0]      i_op,
    input  logic [psrl_pkg::KEY_W-1:0]      i_key,
    input  logic [psrl_pkg::TIME_W-1:0]     i_now,
    input  logic                            i_manual,
    output psrl_pkg::t_dp_sts               o_sts,
    output logic [1:0]                      o_status,
    output logic                            o_ign,
    output logic [psrl_pkg::USED_W-1:0]     o_used
);
    import psrl_pkg::*;

    t_rec mem [TABLE_DEPTH];
    t_rec r_rd;
    t_rec r_rec;

    logic [CMD_W-1:0]  r_op;
    logic [KEY_W-1:0]  r_key;
    logic [TIME_W-1:0] r_now;
    logic              r_manual;
    logic [IDX_W-1:0]  r_idx;
    logic [IDX_W-1:0]  r_slot;
    logic [IDX_W-1:0]  r_min_idx;
    logic [TIME_W-1:0] r_min_time;
    logic [USED_W-1:0] r_used;
    logic [1:0]        r_status;
    logic              r_ign;

    t_rec              exp_rec, upd_rec, alloc_rec;
    logic [1:0]        upd_status;
    logic              upd_ign;
    logic              over;
    logic [TIME_W-1:0] ws;
    logic [CTR_W-1:0]  cnt;
    logic [TIME_W:0]   expiry;
    logic              full;

    assign full = (r_used == USED_W'(TABLE_DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) r_rd <= mem[r_idx];
        if (i_cmd.write) mem[r_slot] <= r_rec;
    end

    assign o_sts.no_op     = (r_op > CMD_QUERY);
    assign o_sts.query     = (r_op == CMD_QUERY);
    assign o_sts.used_zero = (r_used == '0);
    assign o_sts.hit       = (r_rd.key == r_key);
    assign o_sts.last      = ({1'b0, r_idx} == (r_used - 1'b1));

    // fresh entry
    always_comb begin
        alloc_rec            = '0;
        alloc_rec.key        = r_key;
        alloc_rec.touch_time = r_now;
    end

    // last-seen refresh and ignore expiry
    always_comb begin
        exp_rec = r_rec;
        if (r_op != CMD_QUERY) exp_rec.touch_time = r_now;
        if ((r_op == CMD_CHECK_CMD || r_op == CMD_QUERY) && r_rec.ign_flag &&
            r_rec.ign_until != '0 && r_now >= r_rec.ign_until) begin
            exp_rec.ign_flag  = 1'b0;
            exp_rec.ign_until = '0;
            exp_rec.rej_cnt   = '0;
            exp_rec.rej_ws    = r_now;
        end
    end

    always_comb begin
        upd_rec    = r_rec;
        upd_status = ST_OK;
        upd_ign    = 1'b0;
        over       = 1'b0;
        ws         = '0;
        cnt        = '0;
        expiry     = '0;
        unique case (r_op)
            CMD_CHECK_CMD: begin
                over = window_over(r_rec.cmd_ws, r_now, i_cfg.cmd_win);
                ws   = over ? r_now : r_rec.cmd_ws;
                cnt  = over ? '0 : r_rec.cmd_cnt;
                if (r_manual) begin
                    upd_rec.ign_flag  = 1'b1;
                    upd_rec.ign_until = '0;
                    upd_status        = ST_IGNORED;
                end else if (r_rec.ign_flag) begin
                    upd_status = ST_IGNORED;
                end else if (i_cfg.rate_en) begin
                    upd_rec.cmd_ws = ws;
                    if (cnt >= i_cfg.cmd_limit) begin
                        upd_rec.cmd_cnt = cnt;
                        upd_status      = ST_RATE_LIMITED;
                    end else begin
                        upd_rec.cmd_cnt = sat_inc(cnt);
                    end
                end
            end
            CMD_CHECK_REPLY: begin
                over = window_over(r_rec.reply_ws, r_now, i_cfg.reply_win);
                ws   = over ? r_now : r_rec.reply_ws;
                cnt  = over ? '0 : r_rec.reply_cnt;
                upd_rec.reply_ws  = ws;
                upd_rec.reply_cnt = cnt;
                if (cnt >= i_cfg.reply_limit) upd_status = ST_REPLY_LIMITED;
            end
            CMD_REJECTED: begin
                over   = window_over(r_rec.rej_ws, r_now, i_cfg.cmd_win);
                ws     = over ? r_now : r_rec.rej_ws;
                cnt    = sat_inc(over ? '0 : r_rec.rej_cnt);
                expiry = {1'b0, r_now} + {1'b0, i_cfg.ign_dur};
                upd_rec.rej_ws  = ws;
                upd_rec.rej_cnt = cnt;
                if (i_cfg.auto_en && cnt >= i_cfg.rej_thr) begin
                    upd_rec.ign_flag  = 1'b1;
                    upd_rec.ign_until = expiry[TIME_W] ? '1 : expiry[TIME_W-1:0];
                    upd_status        = ST_IGNORED;
                end
            end
            CMD_REPLY_SENT: upd_rec.reply_cnt = sat_inc(r_rec.reply_cnt);
            CMD_QUERY:      upd_ign = r_rec.ign_flag;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (i_cmd.alloc && !full) begin
            r_used <= r_used + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_op     <= i_op;
            r_key    <= i_key;
            r_now    <= i_now;
            r_manual <= i_manual;
            r_idx    <= '0;
            r_status <= ST_OK;
            r_ign    <= 1'b0;
        end
        if (i_cmd.cmp) begin
            // oldest entry, lowest index on a tie
            if (r_idx == '0 || r_rd.touch_time < r_min_time) begin
                r_min_idx  <= r_idx;
                r_min_time <= r_rd.touch_time;
            end
            if (o_sts.hit) begin
                r_rec  <= r_rd;
                r_slot <= r_idx;
            end else begin
                r_idx <= r_idx + 1'b1;
            end
        end
        if (i_cmd.alloc) begin
            r_rec  <= alloc_rec;
            r_slot <= full ? r_min_idx : r_used[IDX_W-1:0];
        end
        if (i_cmd.expire) r_rec <= exp_rec;
        if (i_cmd.update) begin
            r_rec    <= upd_rec;
            r_status <= upd_status;
            r_ign    <= upd_ign;
        end
    end

    assign o_status = r_status;
    assign o_ign    = r_ign;
    assign o_used   = r_used;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= USED_W'(TABLE_DEPTH))
        else $error("entry count overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.alloc && !full) |=> (r_used == $past(r_used) + 1'b1))
        else $error("allocation did not count");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.write |-> ({1'b0, r_slot} < r_used))
        else $error("write beyond used entries");

endmodule

// ===== hw/rtl/per_source_rate_limiter.sv =====
`timescale 1ns / 1ps
// Per-source rate limiter over a 32-entry source table.
// Slave stream: s_tuser = cmd; s_tdata = source_key, now, manual_ignored.
// Master stream: m_tdata = status, is_ignored, entry_count; one beat per item.
// Config channel: cfg_addr picks a register by index, cfg_data is the value;
// always ready, write only while no item is in flight.
// Each item searches the table one entry at a time, a read state then a
// compare state per entry, through the single read port of the table
// memory; the same pass tracks the oldest entry for eviction. The next beat
// is taken in the cycle after the result loads; one item is in work at a
// time, so a new item is not taken before the last one's result loads.
// The output register holds a finished result, so a stalled receiver blocks
// only the next result, and the block keeps accepting until that point.
// Reset clears the entry count and loads the default register values; the
// table contents need no clearing, only entries below the count are read.
module per_source_rate_limiter (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [psrl_pkg::S_DATA_W-1:0]        s_tdata,  // key[51:0] now[83:52] manual[84]
    input  logic [psrl_pkg::CMD_W-1:0]           s_tuser,  // cmd
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [psrl_pkg::M_DATA_W-1:0]        m_tdata,  // status[1:0] ign[2] count[8:3]
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [psrl_pkg::CFG_ADDR_W-1:0]      i_cfg_addr,
    input  logic [psrl_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import psrl_pkg::*;

    t_cfg    r_cfg;
    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;
    logic    in_fire, out_free, out_load;
    logic    r_m_valid;
    logic [M_DATA_W-1:0] r_m_data;
    logic [1:0]          status;
    logic                ign;
    logic [USED_W-1:0]   used;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rate_en     <= 1'b0;
            r_cfg.cmd_win     <= TIME_W'(60);
            r_cfg.cmd_limit   <= CTR_W'(10);
            r_cfg.reply_win   <= TIME_W'(60);
            r_cfg.reply_limit <= CTR_W'(10);
            r_cfg.auto_en     <= 1'b0;
            r_cfg.rej_thr     <= CTR_W'(5);
            r_cfg.ign_dur     <= TIME_W'(600);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_addr)
                CFG_RATE_EN:   r_cfg.rate_en     <= i_cfg_data[0];
                CFG_CMD_WIN:   r_cfg.cmd_win     <= i_cfg_data;
                CFG_CMD_LIMIT: r_cfg.cmd_limit   <= i_cfg_data[CTR_W-1:0];
                CFG_REPLY_WIN: r_cfg.reply_win   <= i_cfg_data;
                CFG_REPLY_LIM: r_cfg.reply_limit <= i_cfg_data[CTR_W-1:0];
                CFG_AUTO_EN:   r_cfg.auto_en     <= i_cfg_data[0];
                CFG_REJ_THR:   r_cfg.rej_thr     <= i_cfg_data[CTR_W-1:0];
                CFG_IGN_DUR:   r_cfg.ign_dur     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !r_m_valid || m_tready;

    psrl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_fire  (in_fire),
        .i_out_free (out_free),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd),
        .o_in_ready (s_tready),
        .o_out_load (out_load)
    );

    psrl_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_cmd    (dp_cmd),
        .i_op     (s_tuser),
        .i_key    (s_tdata[KEY_W-1:0]),
        .i_now    (s_tdata[KEY_W+TIME_W-1:KEY_W]),
        .i_manual (s_tdata[KEY_W+TIME_W]),
        .o_sts    (dp_sts),
        .o_status (status),
        .o_ign    (ign),
        .o_used   (used)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (out_load) begin
            r_m_valid <= 1'b1;
        end else if (m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) r_m_data <= M_DATA_W'({used, ign, status});
    end

    assign m_tvalid = r_m_valid;
    assign m_tdata  = r_m_data;

endmodule
